@@ hw/rtl/b64c_pkg.sv @@
// Shared types, constants and character mapping functions of the base64 codec.
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;
    localparam logic       REG_MODE    = 1'b0;
    localparam int         QUEUE_DEPTH = 2;
    localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int         ADDR_W      = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic        mode;
        logic [23:0] bits;
        logic [1:0]  cnt;
        logic        last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + 8'(v);
        end else if (v < 6'd52) begin
            c = 8'h61 + 8'(v) - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + 8'(v) - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        if (c inside {[8'h41:8'h5A]}) begin
            v = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            v = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 6'd62;
        end else if (c == 8'h2F) begin
            v = 6'd63;
        end else begin
            v = 6'd0;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/b64c_front.sv @@
// Input side of the base64 codec: builds groups and issues one job per finished group that yields a result.
module b64c_front import b64c_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_mode,
    input  logic          i_clear,
    input  logic          i_valid,
    input  t_in_item      i_item,
    output logic          o_stall,
    input  t_queue_status i_qstat,
    output logic          o_push,
    output t_job          o_job
);

    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_cnt, n_cnt;

    logic        accept;
    logic [23:0] enc_bits, dec_bits;
    logic [1:0]  enc_cnt;
    logic [2:0]  dec_cnt;
    logic        enc_emit, dec_flush, dec_full, is_pad;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    always_comb begin
        enc_bits  = {r_bits[15:0], i_item.data_byte};
        enc_cnt   = r_cnt + 2'd1;
        enc_emit  = (enc_cnt == 2'd3) || i_item.last_byte;

        is_pad    = (i_item.data_byte == PAD_CHAR);
        dec_bits  = is_pad ? r_bits : {r_bits[17:0], sextet_of(i_item.data_byte)};
        dec_cnt   = is_pad ? {1'b0, r_cnt} : ({1'b0, r_cnt} + 3'd1);
        dec_full  = !is_pad && (r_cnt == 2'd3);
        dec_flush = dec_full || i_item.last_byte;

        n_bits = r_bits;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_job  = '0;
        o_job.mode = i_mode;
        o_job.last = i_item.last_byte;

        if (i_mode == MODE_ENCODE) begin
            o_job.cnt = enc_cnt;
            case (enc_cnt)
                2'd1:    o_job.bits = enc_bits << 16;
                2'd2:    o_job.bits = enc_bits << 8;
                default: o_job.bits = enc_bits;
            endcase
            if (accept) begin
                o_push = enc_emit;
                n_bits = enc_emit ? 24'd0 : enc_bits;
                n_cnt  = enc_emit ? 2'd0 : enc_cnt;
            end
        end else begin
            o_job.cnt = 2'(dec_cnt - 3'd1);
            case (dec_cnt)
                3'd2:    o_job.bits = dec_bits << 12;
                3'd3:    o_job.bits = dec_bits << 6;
                default: o_job.bits = dec_bits;
            endcase
            if (accept) begin
                o_push = dec_flush && (dec_cnt >= 3'd2);
                n_bits = dec_flush ? 24'd0 : dec_bits;
                n_cnt  = dec_flush ? 2'd0 : dec_cnt[1:0];
            end
        end

        if (i_clear) begin
            n_bits = 24'd0;
            n_cnt  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 24'd0;
            r_cnt  <= 2'd0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/b64c_queue.sv @@
// Short job queue between the front and back parts of the base64 codec.
module b64c_queue import b64c_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_head,
    output t_queue_status o_qstat
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_count;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/b64c_back.sv @@
// Output side of the base64 codec: expands each job into result transactions.
module b64c_back import b64c_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_head,
    input  t_queue_status i_qstat,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output t_out_item     o_item
);

    logic [1:0] r_k;
    logic       r_ov;
    t_out_item  r_out;

    logic       load, at_end;
    logic [1:0] last_idx;
    logic [5:0] sext;
    logic [7:0] ch;

    always_comb begin
        case (r_k)
            2'd0:    sext = i_head.bits[23:18];
            2'd1:    sext = i_head.bits[17:12];
            2'd2:    sext = i_head.bits[11:6];
            default: sext = i_head.bits[5:0];
        endcase

        if (i_head.mode == MODE_ENCODE) begin
            last_idx = 2'd3;
            if ((r_k == 2'd2 && i_head.cnt < 2'd2) || (r_k == 2'd3 && i_head.cnt < 2'd3)) begin
                ch = PAD_CHAR;
            end else begin
                ch = b64_char(sext);
            end
        end else begin
            last_idx = i_head.cnt - 2'd1;
            case (r_k)
                2'd0:    ch = i_head.bits[23:16];
                2'd1:    ch = i_head.bits[15:8];
                default: ch = i_head.bits[7:0];
            endcase
        end

        at_end = (r_k == last_idx);
        load   = !i_qstat.empty && (!r_ov || !i_stall);
        o_pop  = load && at_end;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte <= ch;
            r_out.out_last <= i_head.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= 2'd0;
            r_ov <= 1'b0;
        end else begin
            if (load) begin
                r_k  <= at_end ? 2'd0 : (r_k + 2'd1);
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/base64_codec_stream.sv @@
// Top level of the streaming base64 codec with its mode register port.
//
// Input transactions carry one byte and a last flag on i_valid/o_stall/i_item.
// Result transactions leave on o_valid/i_stall/o_item, one character or byte each.
// The mode register (byte address 0, bit 0) selects encode (0) or decode (1);
// writing it discards any half-built group. Write it only while the block is idle.
// A transaction that completes a group, or carries the last flag, turns into a job
// that waits in a two-entry queue (in decode mode, not if under two sextets came in).
// The output register takes the job's results from the queue head, one per cycle
// while the receiver does not stall, so encoding, which makes four characters of
// three bytes, is held back by the output side; decoding takes one input per cycle.
// When the receiver stalls, the output register holds its transaction, the queue
// fills, and the input side asserts o_stall once the queue is full.
// Reset clears the mode to encode, the open group, the queue and the output valid.
module base64_codec_stream import b64c_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_item
);

    logic          r_mode;
    logic          cfg_wr, mode_hit;
    logic          push, pop;
    t_job          job, head;
    t_queue_status qstat;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign mode_hit = (paddr[ADDR_W-1:2] == REG_MODE) && (paddr[1:0] == 2'd0);
    assign prdata   = mode_hit ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (cfg_wr && mode_hit) begin
            r_mode <= pwdata[0];
        end
    end

    b64c_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_clear (cfg_wr && mode_hit),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (job)
    );

    b64c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    b64c_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

@@ sim/base64_codec_stream_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the streaming base64 codec with a scoreboard and random flow control.
module base64_codec_stream_tb import b64c_pkg::*;;

    class codec_scoreboard;
        logic        mode;
        logic [23:0] group_bits;
        logic [1:0]  group_count;
        t_out_item   expected_q[$];
        int          errors;

        function new();
            mode        = MODE_ENCODE;
            group_bits  = '0;
            group_count = '0;
            errors      = 0;
        endfunction

        function logic [7:0] char_of(input logic [5:0] v);
            string alphabet;
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            return alphabet[v];
        endfunction

        function logic [5:0] value_of(input logic [7:0] c);
            logic [5:0] v;
            if (c >= 8'h41 && c <= 8'h5A) begin
                v = 6'(c - 8'h41);
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                v = 6'(c - 8'h61 + 8'd26);
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = 6'(c - 8'h30 + 8'd52);
            end else if (c == 8'h2B) begin
                v = 6'd62;
            end else if (c == 8'h2F) begin
                v = 6'd63;
            end else begin
                v = 6'd0;
            end
            return v;
        endfunction

        function void write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
            if (addr[ADDR_W-1:2] == REG_MODE) begin
                mode        = value[0];
                group_bits  = '0;
                group_count = '0;
            end
        endfunction

        function void add_expected(input logic [7:0] b, input logic last);
            t_out_item r;
            r.out_byte = b;
            r.out_last = last;
            expected_q.push_back(r);
        endfunction

        function void encode_byte(input t_in_item it);
            logic [23:0] bits;
            logic [1:0]  cnt;
            group_bits  = {group_bits[15:0], it.data_byte};
            group_count = group_count + 2'd1;
            if (group_count == 2'd3 || it.last_byte) begin
                cnt  = group_count;
                bits = group_bits;
                if (cnt == 2'd1) begin
                    bits = bits << 16;
                end else if (cnt == 2'd2) begin
                    bits = bits << 8;
                end
                add_expected(char_of(bits[23:18]), 1'b0);
                add_expected(char_of(bits[17:12]), 1'b0);
                add_expected(cnt >= 2'd2 ? char_of(bits[11:6]) : PAD_CHAR, 1'b0);
                add_expected(cnt == 2'd3 ? char_of(bits[5:0]) : PAD_CHAR, it.last_byte);
                group_bits  = '0;
                group_count = '0;
            end
        endfunction

        function void decode_char(input t_in_item it);
            logic [23:0] bits;
            logic        full;
            int          n;
            int          want;
            full = 1'b0;
            if (it.data_byte != PAD_CHAR) begin
                group_bits = {group_bits[17:0], value_of(it.data_byte)};
                if (group_count == 2'd3) begin
                    full = 1'b1;
                    n    = 4;
                end else begin
                    group_count = group_count + 2'd1;
                    n           = group_count;
                end
            end else begin
                n = group_count;
            end
            if (full || it.last_byte) begin
                bits = group_bits;
                if (n == 2) begin
                    bits = bits << 12;
                end else if (n == 3) begin
                    bits = bits << 6;
                end
                want = (n >= 2) ? n - 1 : 0;
                for (int i = 0; i < want; i++) begin
                    add_expected(bits[23-8*i -: 8], it.last_byte && (i == want - 1));
                end
                group_bits  = '0;
                group_count = '0;
            end
        endfunction

        function void note_input(input t_in_item it);
            if (mode == MODE_ENCODE) begin
                encode_byte(it);
            end else begin
                decode_char(it);
            end
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %h last %b",
                         $time, got.out_byte, got.out_last);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, want.out_byte, got.out_byte);
                    errors++;
                end
                if (got.out_last !== want.out_last) begin
                    $display("%0t: out_last mismatch, expected %b, actual %b",
                             $time, want.out_last, got.out_last);
                    errors++;
                end
            end
        endfunction
    endclass

    localparam logic [ADDR_W-1:0] MODE_ADDR   = ADDR_W'(4 * REG_MODE);
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);
    localparam logic [7:0]        MODE_PLAN   = 8'b0101_0110;
    localparam int                PHASE_ITEMS = 40;
    localparam int                IDLE_PCT    = 28;
    localparam int                DRAIN_WAIT  = 8;
    localparam int                CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid;
    logic              o_stall;
    t_in_item          i_item;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_out_item         o_item;

    codec_scoreboard   sb;
    bit                quiet = 1'b0;
    bit                paused;
    int unsigned       items_sent;
    int unsigned       phase_start;
    int unsigned       cycles = 0;
    int                msg_len;

    base64_codec_stream dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            sb.check_result(o_item);
        end
        i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(addr, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_mode_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MODE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[0] !== sb.mode) begin
            $display("%0t: mode readback mismatch, expected %b, actual %b",
                     $time, sb.mode, prdata[0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] data, input logic last);
        t_in_item it;
        it.data_byte = data;
        it.last_byte = last;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_input(it);
        items_sent++;
    endtask

    // Waits until every expected transaction has arrived and the queue has had time to empty.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_message(input int len);
        int pad;
        int total;
        if (sb.mode == MODE_ENCODE) begin
            for (int i = 0; i < len; i++) begin
                send_item(8'($urandom_range(255)), i == len - 1);
            end
        end else if ($urandom_range(99) < 75) begin
            pad   = ((len % 4) != 0 && $urandom_range(3) != 0) ? 4 - (len % 4) : 0;
            total = len + pad;
            for (int i = 0; i < total; i++) begin
                send_item(i < len ? sb.char_of(6'($urandom_range(63))) : PAD_CHAR,
                          i == total - 1);
            end
        end else begin
            for (int i = 0; i < len; i++) begin
                send_item(($urandom_range(7) == 0) ? PAD_CHAR : 8'($urandom_range(255)),
                          (i == len - 1) || ($urandom_range(15) == 0));
            end
        end
    endtask

    initial begin
        sb         = new();
        items_sent = 0;
        paused     = 1'b0;
        i_rst_n   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        i_valid   <= 1'b0;
        i_item    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_mode_readback();
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b1);
        send_item(8'h12, 1'b0);
        settle();
        apb_write(UNUSED_ADDR, 32'h1);
        check_mode_readback();
        send_item(8'h34, 1'b1);
        send_item(8'h56, 1'b0);
        settle();
        apb_write(MODE_ADDR, {31'b0, MODE_DECODE});
        check_mode_readback();
        send_item("Q", 1'b0);
        send_item("U", 1'b0);
        send_item("J", 1'b0);
        send_item("D", 1'b1);
        send_item("Q", 1'b0);
        send_item("Q", 1'b0);
        send_item(PAD_CHAR, 1'b1);
        send_item("Q", 1'b1);
        send_item(PAD_CHAR, 1'b1);
        send_item("Q", 1'b0);
        send_item(PAD_CHAR, 1'b0);
        send_item("U", 1'b1);
        send_item(8'h2A, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h2B, 1'b0);
        send_item(8'h2F, 1'b1);

        for (int p = 0; p < 8; p++) begin
            settle();
            apb_write(MODE_ADDR, {31'b0, MODE_PLAN[p]});
            check_mode_readback();
            quiet       = (p == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (p == 5 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
                msg_len = ($urandom_range(9) == 0) ? $urandom_range(13, 24)
                                                   : $urandom_range(1, 10);
                send_message(msg_len);
            end
            quiet = 1'b0;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
